/* hw/rtl/ppds_pkg.sv */
// Shared types and constants for the pixel pair divergence statistics block.
// Holds the request and result payload structs, the bucket codes and the register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppds_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int COORD_BITS   = 12;
  localparam int COUNT_BITS   = 32;
  localparam int SUM_BITS     = 48;
  localparam int PSUM_BITS    = CHANNEL_BITS + 2;
  localparam int NUM_BUCKETS  = 4;
  localparam int BUCKET_BITS  = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CHANNEL_BITS-1:0] TOLERANCE_RESET    = CHANNEL_BITS'(0);
  localparam logic [CHANNEL_BITS-1:0] SMALL_LIMIT_RESET  = CHANNEL_BITS'(3277);
  localparam logic [CHANNEL_BITS-1:0] MEDIUM_LIMIT_RESET = CHANNEL_BITS'(13107);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TOLERANCE    = 2'd0,
    REG_SMALL_LIMIT  = 2'd1,
    REG_MEDIUM_LIMIT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  typedef enum logic [BUCKET_BITS-1:0] {
    BKT_WITHIN = 2'd0,
    BKT_SMALL  = 2'd1,
    BKT_MEDIUM = 2'd2,
    BKT_LARGE  = 2'd3
  } bucket_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] ref_red;
    logic [CHANNEL_BITS-1:0] ref_green;
    logic [CHANNEL_BITS-1:0] ref_blue;
    logic [CHANNEL_BITS-1:0] ref_alpha;
    logic [CHANNEL_BITS-1:0] cmp_red;
    logic [CHANNEL_BITS-1:0] cmp_green;
    logic [CHANNEL_BITS-1:0] cmp_blue;
    logic [CHANNEL_BITS-1:0] cmp_alpha;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic                    clear_stats;
  } pixel_pair_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] pixel_peak;
    logic [BUCKET_BITS-1:0]  bucket;
    logic [CHANNEL_BITS-1:0] frame_peak;
    logic [COORD_BITS-1:0]   worst_col;
    logic [COORD_BITS-1:0]   worst_row;
    logic [COUNT_BITS-1:0]   count_within_tol;
    logic [COUNT_BITS-1:0]   count_small;
    logic [COUNT_BITS-1:0]   count_medium;
    logic [COUNT_BITS-1:0]   count_large;
    logic [SUM_BITS-1:0]     diff_sum;
    logic                    consistent;
  } divergence_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0]                      peak;
    logic [COORD_BITS-1:0]                        worst_col;
    logic [COORD_BITS-1:0]                        worst_row;
    logic [NUM_BUCKETS-1:0][COUNT_BITS-1:0]       counts;
    logic [SUM_BITS-1:0]                          diff_sum;
  } stats_t;

endpackage

`default_nettype wire

/* hw/rtl/ppds_diff.sv */
// Channel difference unit: four absolute differences, their maximum and their sum.
// Purely combinational; uses ppds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppds_diff (
  input  ppds_pkg::pixel_pair_t                  pair,
  output logic [ppds_pkg::CHANNEL_BITS-1:0]      pmax,
  output logic [ppds_pkg::PSUM_BITS-1:0]         psum
);
  import ppds_pkg::*;

  logic [CHANNEL_BITS-1:0] d_red;
  logic [CHANNEL_BITS-1:0] d_green;
  logic [CHANNEL_BITS-1:0] d_blue;
  logic [CHANNEL_BITS-1:0] d_alpha;
  logic [CHANNEL_BITS-1:0] max_rg;
  logic [CHANNEL_BITS-1:0] max_ba;

  function automatic logic [CHANNEL_BITS-1:0] abs_diff(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign d_red   = abs_diff(pair.ref_red,   pair.cmp_red);
  assign d_green = abs_diff(pair.ref_green, pair.cmp_green);
  assign d_blue  = abs_diff(pair.ref_blue,  pair.cmp_blue);
  assign d_alpha = abs_diff(pair.ref_alpha, pair.cmp_alpha);

  assign max_rg = (d_red > d_green) ? d_red : d_green;
  assign max_ba = (d_blue > d_alpha) ? d_blue : d_alpha;
  assign pmax   = (max_rg > max_ba) ? max_rg : max_ba;

  assign psum = PSUM_BITS'(d_red) + PSUM_BITS'(d_green)
              + PSUM_BITS'(d_blue) + PSUM_BITS'(d_alpha);

endmodule

`default_nettype wire

/* hw/rtl/ppds_accum.sv */
// Running statistics: worst difference and its coordinate, bucket counts and difference sum.
// Counters and the sum saturate; uses ppds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppds_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               update,
  input  logic                               clear,
  input  logic [ppds_pkg::CHANNEL_BITS-1:0]  pmax,
  input  logic [ppds_pkg::PSUM_BITS-1:0]     psum,
  input  logic [ppds_pkg::COORD_BITS-1:0]    px,
  input  logic [ppds_pkg::COORD_BITS-1:0]    py,
  input  ppds_pkg::bucket_t                  bkt,
  output ppds_pkg::stats_t                   stats
);
  import ppds_pkg::*;

  stats_t                stats_base;
  stats_t                stats_next;
  logic [SUM_BITS:0]     sum_wide;

  always_comb begin
    stats_base = clear ? '0 : stats;
    stats_next = stats_base;

    if (pmax > stats_base.peak) begin
      stats_next.peak      = pmax;
      stats_next.worst_col = px;
      stats_next.worst_row = py;
    end

    sum_wide = {1'b0, stats_base.diff_sum} + (SUM_BITS + 1)'(psum);
    stats_next.diff_sum = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if ((BUCKET_BITS'(i) == bkt) && (stats_base.counts[i] != '1)) begin
        stats_next.counts[i] = stats_base.counts[i] + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (update) begin
      stats <= stats_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pixel_pair_divergence_stats.sv */
// Top level of the pixel pair divergence statistics block.
// Instantiates ppds_diff and ppds_accum; uses ppds_pkg.
//
// Usage: each request on the pix channel carries one RGBA pixel from the reference
// path and one from the compared path, with the pixel coordinate and a clear flag.
// Every request yields exactly one result on the res channel: the pixel's largest
// channel difference, its bucket, and the running statistics after this pixel.
// A request with clear_stats set starts a new frame: statistics restart from zero
// and then this pixel is counted.
// An accepted request sits in the input register until its result is loaded into the
// result register together with the statistics registers. Throughput is one request
// per cycle while no result is held waiting by res_stall.
// The cfg port writes tolerance, small_limit and medium_limit; write them only while
// no request is in flight. Reset clears the statistics, empties the pipeline and loads
// the default limits.
// When res_stall is held with a result waiting, both registers hold and pix_stall
// rises in the same cycle; the waiting result stays unchanged until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module pixel_pair_divergence_stats (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  ppds_pkg::pixel_pair_t                pix,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output ppds_pkg::divergence_t                res,
  input  logic                                 cfg_write,
  input  logic [ppds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ppds_pkg::CHANNEL_BITS-1:0]    cfg_data
);
  import ppds_pkg::*;

  logic [CHANNEL_BITS-1:0] tolerance;
  logic [CHANNEL_BITS-1:0] small_limit;
  logic [CHANNEL_BITS-1:0] medium_limit;

  logic                    advance;

  logic                    s1_valid;
  pixel_pair_t             s1;

  logic [CHANNEL_BITS-1:0] d_pmax;
  logic [PSUM_BITS-1:0]    d_psum;
  bucket_t                 d_bucket;

  logic [CHANNEL_BITS-1:0] res_pmax;
  bucket_t                 res_bucket;
  stats_t                  stats;

  assign advance   = !(res_valid && res_stall);
  assign pix_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= TOLERANCE_RESET;
      small_limit  <= SMALL_LIMIT_RESET;
      medium_limit <= MEDIUM_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TOLERANCE:    tolerance    <= cfg_data;
        REG_SMALL_LIMIT:  small_limit  <= cfg_data;
        REG_MEDIUM_LIMIT: medium_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pix_valid;
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pix_valid) begin
        s1 <= pix;
      end
      if (s1_valid) begin
        res_pmax   <= d_pmax;
        res_bucket <= d_bucket;
      end
    end
  end

  ppds_diff u_diff (
    .pair (s1),
    .pmax (d_pmax),
    .psum (d_psum)
  );

  always_comb begin
    priority if (d_pmax <= tolerance) begin
      d_bucket = BKT_WITHIN;
    end else if (d_pmax <= small_limit) begin
      d_bucket = BKT_SMALL;
    end else if (d_pmax <= medium_limit) begin
      d_bucket = BKT_MEDIUM;
    end else begin
      d_bucket = BKT_LARGE;
    end
  end

  ppds_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .update (s1_valid && advance),
    .clear  (s1.clear_stats),
    .pmax   (d_pmax),
    .psum   (d_psum),
    .px     (s1.pixel_x),
    .py     (s1.pixel_y),
    .bkt    (d_bucket),
    .stats  (stats)
  );

  always_comb begin
    res.pixel_peak       = res_pmax;
    res.bucket           = res_bucket;
    res.frame_peak       = stats.peak;
    res.worst_col        = stats.worst_col;
    res.worst_row        = stats.worst_row;
    res.count_within_tol = stats.counts[BKT_WITHIN];
    res.count_small      = stats.counts[BKT_SMALL];
    res.count_medium     = stats.counts[BKT_MEDIUM];
    res.count_large      = stats.counts[BKT_LARGE];
    res.diff_sum         = stats.diff_sum;
    res.consistent       = (stats.peak <= tolerance);
  end

endmodule

`default_nettype wire
